FILE: sv/gcg_pkg.sv
// Shared types and constants for the Gilbert curve coordinate generator.
`timescale 1ns / 1ps
package gcg_pkg;

   localparam int unsigned SIDE_W = 13;   // width of one side register
   localparam int unsigned CRD_W  = 12;   // width of an emitted coordinate
   localparam int unsigned VEC_W  = 14;   // signed vector component width
   localparam int unsigned POS_W  = 14;   // signed position width
   localparam int unsigned MAX_SIDE = 4096; // largest side after clamping

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_WAIT   = 7'b0001000,
      ST_EVAL   = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;     // load the root frame
      logic rd;        // read the top frame
      logic eval;      // act on the top frame
      logic emit;      // capture a pixel and advance the run
      logic blank;     // capture an empty result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic run_busy;  // a run is loaded
      logic stk_empty; // no frame on the stack
   } sts_type;

endpackage

FILE: sv/gcg_datapath.sv
// Frame stack, split arithmetic, run counter and output register.
`timescale 1ns / 1ps
module gcg_datapath #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gcg_pkg::cmd_type            cmd,
   output gcg_pkg::sts_type            sts,
   input  logic [gcg_pkg::SIDE_W-1:0]  width_val,
   input  logic [gcg_pkg::SIDE_W-1:0]  height_val,
   output logic [gcg_pkg::CRD_W-1:0]   coord_x,
   output logic [gcg_pkg::CRD_W-1:0]   coord_y,
   output logic                        is_last,
   output logic                        valid_res
);
   import gcg_pkg::*;

   localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned IX_W = $clog2(STACK_DEPTH);
   localparam int unsigned FR_W = 2 * POS_W + 4 * VEC_W;

   typedef logic signed [VEC_W-1:0] vec_type;

   // frame memory: origin, vectors; phase kept beside it
   logic [FR_W-1:0] mem [STACK_DEPTH];
   logic [1:0]      phase_mem [STACK_DEPTH];
   logic [FR_W-1:0] frame_ff;
   logic [1:0]      phase_ff;

   logic [SP_W-1:0] sp_ff, sp_in;
   logic signed [POS_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [1:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [SIDE_W-1:0] rem_ff, rem_in;
   logic [CRD_W-1:0] ox_ff, oy_ff;
   logic ol_ff, ov_ff;

   logic            wr_en;
   logic [IX_W-1:0] wr_idx;
   logic [FR_W-1:0] wr_data;
   logic            ph_en;
   logic [IX_W-1:0] ph_idx;
   logic [1:0]      ph_data;

   logic phase_zero_en;
   logic [STACK_DEPTH-1:0] fresh_ff, fresh_in;

   logic [IX_W-1:0] top_idx;
   assign top_idx = IX_W'(sp_ff - SP_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (ph_en) begin
         phase_mem[ph_idx] <= ph_data;
      end
      if (cmd.rd) begin
         frame_ff <= mem[top_idx];
         phase_ff <= fresh_ff[top_idx] ? 2'd0 : phase_mem[top_idx];
      end
   end

   // unpack the top frame
   vec_type fx, fy, ax, ay, bx, by;
   assign {fx, fy, ax, ay, bx, by} = frame_ff;

   function automatic vec_type mag(input vec_type v);
      mag = v[VEC_W-1] ? -v : v;
   endfunction
   function automatic vec_type sgn(input vec_type v);
      sgn = v[VEC_W-1] ? -vec_type'(1) : ((v != '0) ? vec_type'(1) : '0);
   endfunction
   function automatic vec_type half(input vec_type v);
      half = (v + vec_type'(v[VEC_W-1])) >>> 1;
   endfunction

   vec_type w, h, dax, day, dbx, dby, ax2, ay2, bx2, by2, w2, h2;
   vec_type cx, cy, cax, cay, cbx, cby;
   logic two_way, leaf, split_done;
   logic [1:0] nsub, k;
   logic [VEC_W+1:0] w_x2, h_x3;

   always_comb begin
      w   = mag(ax + ay);
      h   = mag(bx + by);
      dax = sgn(ax); day = sgn(ay); dbx = sgn(bx); dby = sgn(by);
      ax2 = half(ax); ay2 = half(ay); bx2 = half(bx); by2 = half(by);
      w2  = mag(ax2 + ay2);
      h2  = mag(bx2 + by2);
      w_x2 = (VEC_W+2)'({w, 1'b0});
      h_x3 = (VEC_W+2)'({h, 1'b0}) + (VEC_W+2)'(h);
      two_way = w_x2 > h_x3;
      leaf = (phase_ff == 2'd0) && (w <= vec_type'(1) || h <= vec_type'(1));
      nsub = two_way ? 2'd2 : 2'd3;
      k = phase_ff;
      cx = fx; cy = fy; cax = '0; cay = '0; cbx = '0; cby = '0;
      if (two_way) begin
         if (w2[0] && w > vec_type'(2)) begin
            ax2 = ax2 + dax; ay2 = ay2 + day;
         end
         if (k == 2'd0) begin
            cax = ax2; cay = ay2; cbx = bx; cby = by;
         end else begin
            cx = fx + ax2; cy = fy + ay2;
            cax = ax - ax2; cay = ay - ay2; cbx = bx; cby = by;
         end
      end else begin
         if (h2[0] && h > vec_type'(2)) begin
            bx2 = bx2 + dbx; by2 = by2 + dby;
         end
         if (k == 2'd0) begin
            cax = bx2; cay = by2; cbx = ax2; cby = ay2;
         end else if (k == 2'd1) begin
            cx = fx + bx2; cy = fy + by2;
            cax = ax; cay = ay; cbx = bx - bx2; cby = by - by2;
         end else begin
            cx = fx + (ax - dax) + (bx2 - dbx);
            cy = fy + (ay - day) + (by2 - dby);
            cax = -bx2; cay = -by2; cbx = -(ax - ax2); cby = -(ay - ay2);
         end
      end
      split_done = k >= nsub;
   end

   logic [SIDE_W-1:0] cw, ch;
   always_comb begin
      cw = (width_val == '0) ? SIDE_W'(1) :
           (width_val > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_val;
      ch = (height_val == '0) ? SIDE_W'(1) :
           (height_val > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_val;
   end

   always_comb begin
      sp_in = sp_ff; px_in = px_ff; py_in = py_ff;
      sx_in = sx_ff; sy_in = sy_ff; rem_in = rem_ff;
      wr_en = 1'b0; wr_idx = IX_W'(sp_ff); wr_data = '0;
      ph_en = 1'b0; ph_idx = top_idx; ph_data = '0;
      if (cmd.start) begin
         wr_en = 1'b1; wr_idx = '0;
         ph_en = 1'b1; ph_idx = '0;
         rem_in = '0;
         sp_in = SP_W'(1);
         if (cw >= ch) begin
            wr_data = {POS_W'(0), POS_W'(0), VEC_W'(cw), VEC_W'(0), VEC_W'(0), VEC_W'(ch)};
         end else begin
            wr_data = {POS_W'(0), POS_W'(0), VEC_W'(0), VEC_W'(ch), VEC_W'(cw), VEC_W'(0)};
         end
      end else if (cmd.eval) begin
         if (leaf) begin
            px_in = fx; py_in = fy;
            sp_in = sp_ff - SP_W'(1);
            if (w == '0 || h == '0) begin
               rem_in = '0;
            end else if (h == vec_type'(1)) begin
               sx_in = 2'(sgn(ax)); sy_in = 2'(sgn(ay));
               rem_in = SIDE_W'(w);
            end else begin
               sx_in = 2'(sgn(bx)); sy_in = 2'(sgn(by));
               rem_in = SIDE_W'(h);
            end
         end else if (split_done) begin
            sp_in = sp_ff - SP_W'(1);
         end else begin
            ph_en = 1'b1; ph_data = k + 2'd1;
            if (sp_ff < SP_W'(STACK_DEPTH)) begin
               wr_en = 1'b1;
               wr_data = {cx, cy, cax, cay, cbx, cby};
               sp_in = sp_ff + SP_W'(1);
            end
         end
      end else if (cmd.emit) begin
         px_in = px_ff + POS_W'(sx_ff);
         py_in = py_ff + POS_W'(sy_ff);
         rem_in = rem_ff - SIDE_W'(1);
      end
      // a push marks the new slot fresh so it reads as phase zero; the parent's bump uses ph port
      if (wr_en && !cmd.start) begin
         phase_zero_en = 1'b1;
      end else begin
         phase_zero_en = 1'b0;
      end
   end

   // a freshly pushed frame has phase zero; track that with a per-slot flag
   always_comb begin
      fresh_in = fresh_ff;
      if (ph_en) begin
         fresh_in[ph_idx] = cmd.start;
      end
      if (phase_zero_en) begin
         fresh_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         rem_ff   <= '0;
         ov_ff    <= 1'b0;
         fresh_ff <= '0;
      end else begin
         sp_ff    <= sp_in;
         rem_ff   <= rem_in;
         fresh_ff <= fresh_in;
         if (cmd.emit) begin
            ov_ff <= 1'b1;
         end else if (cmd.blank) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      if (cmd.emit) begin
         ox_ff <= CRD_W'(px_ff);
         oy_ff <= CRD_W'(py_ff);
      end else if (cmd.blank) begin
         ox_ff <= '0;
         oy_ff <= '0;
      end
   end

   // is_last is known only after the stack is resolved; set once a pixel leaves no run and no frame
   always_ff @(posedge clock) begin
      if (reset) begin
         ol_ff <= 1'b0;
      end else if (cmd.emit || cmd.blank) begin
         ol_ff <= 1'b0;
      end else if (ov_ff && rem_ff == '0 && sp_ff == '0) begin
         ol_ff <= 1'b1;
      end
   end

   assign sts.run_busy  = rem_ff != '0;
   assign sts.stk_empty = sp_ff == '0;
   assign coord_x   = ox_ff;
   assign coord_y   = oy_ff;
   assign is_last   = ol_ff;
   assign valid_res = ov_ff;

`ifndef SYNTHESIS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH)) else $error("stack pointer overflow");
   a_emit_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rem_ff != '0) else $error("emit without a run");
   a_eval_stack: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> sp_ff != '0) else $error("evaluate on empty stack");
`endif
endmodule

FILE: sv/gcg_control.sv
// Sequencer: restarts, stack resolution and result handshake.
`timescale 1ns / 1ps
module gcg_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gcg_pkg::cmd_type  cmd,
   input  gcg_pkg::sts_type  sts
);
   import gcg_pkg::*;

   state_type state_ff, state_in;
   logic emitting_ff, emitting_in;  // resolving after a pixel, not before

   always_comb begin
      state_in = state_ff;
      emitting_in = emitting_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  state_in = ST_START;
               end else if (sts.run_busy) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.blank = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            emitting_in = 1'b0;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (sts.run_busy) begin
               state_in = emitting_ff ? ST_OUT : ST_EMIT;
            end else if (sts.stk_empty) begin
               if (emitting_ff) begin
                  state_in = ST_OUT;
               end else begin
                  cmd.blank = 1'b1;
                  state_in = ST_OUT;
               end
            end else begin
               cmd.rd = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_READ;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            emitting_in = 1'b1;
            state_in = ST_READ;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         emitting_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         emitting_ff <= emitting_in;
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.rd, cmd.eval, cmd.emit, cmd.blank}))
      else $error("conflicting commands");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> state_ff == ST_IDLE)
      else $error("result not retired");
`endif
endmodule

FILE: sv/gilbert_curve_coordinate_generator.sv
// Top level of the Gilbert curve coordinate generator.
`timescale 1ns / 1ps
// Usage
//   Write width (index 0) and height (index 1) through the csr_ port while
//   idle; they take effect at the next restart and are clamped to
//   [1, MAX_SIDE]. Each word on the req_ channel yields one word on the
//   rsp_ channel: req_restart=1 begins a new walk and returns its first
//   pixel, req_restart=0 returns the next pixel. Once the walk is over,
//   rsp_valid_res is 0 and the coordinates are 0; rsp_is_last marks the
//   final pixel.
// Sequence
//   A pixel inside a run passes the EMIT and READ states before rsp_valid
//   rises in OUT. When a run ends, the frame stack is worked one frame at a
//   time through READ, WAIT (memory read) and EVAL, for each frame visited;
//   a restart first passes START and works the frames on the way down from
//   the root. An empty result goes from IDLE straight to OUT. One word is in
//   flight: a new req_ word is taken only in IDLE.
// Reset and stall
//   Reset empties the stack and ends any walk. A stalled rsp_ holds the
//   result and the block takes no new req_ word until it is taken.
module gilbert_curve_coordinate_generator #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gcg_pkg::CRD_W-1:0]   rsp_coord_x,
   output logic [gcg_pkg::CRD_W-1:0]   rsp_coord_y,
   output logic                        rsp_is_last,
   output logic                        rsp_valid_res,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [gcg_pkg::SIDE_W-1:0]  csr_data
);
   import gcg_pkg::*;

   logic [SIDE_W-1:0] width_ff, height_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIDE_W'(1);
         height_ff <= SIDE_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gcg_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_restart,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   gcg_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .width_val(width_ff), .height_val(height_ff),
      .coord_x(rsp_coord_x), .coord_y(rsp_coord_y),
      .is_last(rsp_is_last), .valid_res(rsp_valid_res)
   );
endmodule

FILE: tb/testbench.sv
// Testbench for the Gilbert curve coordinate generator: scoreboard and drivers.
`timescale 1ns / 1ps
module testbench;
   import gcg_pkg::*;

   typedef struct {
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] y;
      logic             last;
      logic             vld;
   } pixel_type;

   // Walk predictor with its own frame stack and side registers
   class walk_scoreboard;
      int side_w, side_h;
      int fo[32][2];
      int fv[32][4];
      int fph[32];
      int sp, px, py, sx, sy, remain;
      bit done;
      pixel_type pending[$];
      int errors, shown;

      function void clear();
         side_w = 1; side_h = 1; sp = 0; px = 0; py = 0; sx = 0; sy = 0;
         remain = 0; done = 1; errors = 0; shown = 0;
      endfunction

      function void set_side(logic idx, int v);
         if (idx == CSR_WIDTH) side_w = v & 'h1FFF;
         else side_h = v & 'h1FFF;
      endfunction

      function int sgn(int v);
         return (v > 0) - (v < 0);
      endfunction

      function int mag(int v);
         return v < 0 ? -v : v;
      endfunction

      function void push(int x, int y, int ax, int ay, int bx, int by);
         if (sp >= 32) return;
         fo[sp][0] = x; fo[sp][1] = y;
         fv[sp][0] = ax; fv[sp][1] = ay; fv[sp][2] = bx; fv[sp][3] = by;
         fph[sp] = 0;
         sp++;
      endfunction

      // Sub-frame k of frame t; returns the number of sub-frames
      function int split(int t, int k, output int co[2], output int cv[4]);
         int x, y, ax, ay, bx, by, w, h, dax, day, dbx, dby, ax2, ay2, bx2, by2;
         x = fo[t][0]; y = fo[t][1];
         ax = fv[t][0]; ay = fv[t][1]; bx = fv[t][2]; by = fv[t][3];
         w = mag(ax + ay); h = mag(bx + by);
         dax = sgn(ax); day = sgn(ay); dbx = sgn(bx); dby = sgn(by);
         ax2 = ax / 2; ay2 = ay / 2; bx2 = bx / 2; by2 = by / 2;
         if (2 * w > 3 * h) begin
            if ((mag(ax2 + ay2) & 1) != 0 && w > 2) begin
               ax2 += dax; ay2 += day;
            end
            if (k == 0) begin
               co = '{x, y}; cv = '{ax2, ay2, bx, by};
            end else begin
               co = '{x + ax2, y + ay2}; cv = '{ax - ax2, ay - ay2, bx, by};
            end
            return 2;
         end
         if ((mag(bx2 + by2) & 1) != 0 && h > 2) begin
            bx2 += dbx; by2 += dby;
         end
         if (k == 0) begin
            co = '{x, y}; cv = '{bx2, by2, ax2, ay2};
         end else if (k == 1) begin
            co = '{x + bx2, y + by2}; cv = '{ax, ay, bx - bx2, by - by2};
         end else begin
            co = '{x + (ax - dax) + (bx2 - dbx), y + (ay - day) + (by2 - dby)};
            cv = '{-bx2, -by2, -(ax - ax2), -(ay - ay2)};
         end
         return 3;
      endfunction

      function void find_run();
         int guard, t, w, h, k, n;
         int co[2];
         int cv[4];
         guard = 4 * 32 + 16;
         while (remain == 0 && sp > 0 && guard > 0) begin
            t = sp - 1;
            w = mag(fv[t][0] + fv[t][1]); h = mag(fv[t][2] + fv[t][3]);
            guard--;
            if (fph[t] == 0 && (w <= 1 || h <= 1)) begin
               px = fo[t][0]; py = fo[t][1];
               if (w == 0 || h == 0) remain = 0;
               else if (h == 1) begin
                  sx = sgn(fv[t][0]); sy = sgn(fv[t][1]); remain = w;
               end else begin
                  sx = sgn(fv[t][2]); sy = sgn(fv[t][3]); remain = h;
               end
               sp--;
            end else begin
               k = fph[t];
               n = split(t, k < 3 ? k : 2, co, cv);
               if (k >= n) sp--;
               else begin
                  fph[t] = k + 1;
                  push(co[0], co[1], cv[0], cv[1], cv[2], cv[3]);
               end
            end
         end
         if (remain == 0) begin
            done = 1; sp = 0;
         end
      endfunction

      function void note_request(logic restart);
         pixel_type p;
         int w, h;
         if (restart) begin
            w = side_w < 1 ? 1 : (side_w > 4096 ? 4096 : side_w);
            h = side_h < 1 ? 1 : (side_h > 4096 ? 4096 : side_h);
            sp = 0; remain = 0; done = 0;
            if (w >= h) push(0, 0, w, 0, 0, h);
            else push(0, 0, 0, h, w, 0);
            find_run();
         end
         if (done || remain == 0) begin
            p = '{0, 0, 0, 0};
         end else begin
            p.x = px[CRD_W-1:0]; p.y = py[CRD_W-1:0];
            px += sx; py += sy; remain--;
            if (remain == 0) find_run();
            p.last = done; p.vld = 1;
         end
         pending.push_back(p);
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type e;
         if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected response word x=%0d y=%0d", got.x, got.y);
            end
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (e.x !== got.x || e.y !== got.y || e.last !== got.last || e.vld !== got.vld)
         begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: exp x=%0d y=%0d last=%0d vld=%0d",
                        e.x, e.y, e.last, e.vld);
               $display("          got x=%0d y=%0d last=%0d vld=%0d",
                        got.x, got.y, got.last, got.vld);
            end
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_restart = 0, rsp_ready = 0;
   logic csr_write = 0, csr_index = 0;
   logic [SIDE_W-1:0] csr_data = 0;
   logic req_ready, rsp_valid, rsp_is_last, rsp_valid_res;
   logic [CRD_W-1:0] rsp_coord_x, rsp_coord_y;
   int send_idle = 0, recv_stall = 0;
   int hold_req = 0, hold_ack = 0, hold_cnt = 0;
   longint cycles = 0;
   walk_scoreboard board;

   gilbert_curve_coordinate_generator dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Sample results at the rising edge
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && rsp_ready)
         board.check_pixel('{rsp_coord_x, rsp_coord_y, rsp_is_last, rsp_valid_res});
      if (cycles > 3000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_ready <= 0;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_req != hold_ack) begin
         rsp_ready <= 0;
         hold_ack <= hold_req;
         hold_cnt <= 300;
      end else
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   task automatic write_side(logic idx, int v);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= v[SIDE_W-1:0];
      board.set_side(idx, v);
      @(negedge clock);
      csr_write <= 0;
   endtask

   // Keep valid up between back-to-back words; drop it only while idle
   task automatic send_word(logic restart);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      board.note_request(restart);
      @(negedge clock);
   endtask

   task automatic drain();
      int n;
      req_valid <= 0;
      n = 0;
      while (board.pending.size() != 0 && n < 200000) begin
         @(negedge clock);
         n++;
      end
      repeat (400) @(negedge clock);
   endtask

   // Whole walk of the configured rectangle, plus a few words past its end
   task automatic walk(int w, int h, int extra);
      int n;
      write_side(CSR_WIDTH, w);
      write_side(CSR_HEIGHT, h);
      n = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
      send_word(1);
      for (int i = 1; i < n + extra; i++) send_word($urandom_range(99) < 2);
      drain();
   endtask

   initial begin
      int w, h, cnt;
      board = new();
      board.clear();
      repeat (5) @(negedge clock);
      reset <= 0;
      // Directed: no walk yet, smallest and degenerate sides, out-of-range clamp
      send_word(0);
      drain();
      walk(1, 1, 2);
      walk(0, 3, 1);
      walk(5, 1, 1);
      walk(1, 4, 1);
      walk(3, 2, 1);
      // Widest and tallest sides clamp to the maximum; take a few pixels only
      write_side(CSR_WIDTH, 8191);
      write_side(CSR_HEIGHT, 4096);
      send_word(1);
      repeat (4) send_word(0);
      drain();
      write_side(CSR_WIDTH, 4096);
      write_side(CSR_HEIGHT, 1);
      send_word(1); send_word(0);
      drain();
      // Random walks under the idling phases
      cnt = 0;
      for (int ph = 0; ph < 5; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? 88 : (ph == 4 ? 11 : 0);
         recv_stall = (ph == 2) ? 88 : (ph == 4 ? 11 : 0);
         if (ph == 0) hold_req++;
         for (int j = 0; j < 5; j++) begin
            w = $urandom_range(12, 1); h = $urandom_range(12, 1);
            if ($urandom_range(9) == 0) w = $urandom_range(8191);
            if ($urandom_range(9) == 0) h = $urandom_range(8191);
            if (w * h > 60 || w == 0 || h == 0) begin
               write_side(CSR_WIDTH, w);
               write_side(CSR_HEIGHT, h);
               send_word(1);
               repeat ($urandom_range(20)) send_word($urandom_range(9) == 0);
               drain();
            end else walk(w, h, $urandom_range(2));
         end
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
